### design/http_response_header_parser_macros.svh
// Assertion macros used by the HTTP response header parser checker.
`ifndef HTTP_RESPONSE_HEADER_PARSER_MACROS_SVH
`define HTTP_RESPONSE_HEADER_PARSER_MACROS_SVH

// A condition that must hold in the same cycle as its trigger.
`define HRHP_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("HRHP assertion failed");

// A word that is offered and not taken stays offered and unchanged.
`define HRHP_ASSERT_HOLD(label, clk, rstn, vld, rdy, sig) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) \
    ((vld) && !(rdy)) |=> ((vld) && $stable(sig))) \
    else $error("HRHP assertion failed");

`endif

### design/hrhp_pkg.sv
// Types, constants and helper functions of the HTTP response header parser.
package hrhp_pkg;

  localparam int unsigned LENGTH_BITS = 48;
  localparam int unsigned OUT_LEN_W   = 48;
  localparam int unsigned CODE_W      = 10;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX   = '1;
  localparam logic [LENGTH_BITS-1:0] LEN_DIV10 = LEN_MAX / 10;
  localparam logic [3:0]             LEN_MOD10 = 4'(LEN_MAX % 10);
  localparam logic [OUT_LEN_W-1:0]   LEN_SAT_OUT = OUT_LEN_W'(LEN_MAX);

  localparam int unsigned LEN_MARKER_LEN = 14;
  localparam int unsigned LEN_IDX_W      = $clog2(LEN_MARKER_LEN + 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_C     = 8'h43;

  typedef enum logic [1:0] {
    RES_OK          = 2'd0,
    RES_NO_MARKER   = 2'd1,
    RES_BAD_VERSION = 2'd2,
    RES_BAD_DIGITS  = 2'd3
  } status_res_e;

  typedef struct packed {
    logic       active;
    logic       finish;
    logic [7:0] char;
  } byte_ctl_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    status_res_e       result;
  } status_out_t;

  typedef struct packed {
    logic [OUT_LEN_W-1:0] length;
    logic                 overflow;
  } length_out_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [3:0] digit_value(logic [7:0] c);
    logic [7:0] diff;
    diff = c - CH_ZERO;
    return diff[3:0];
  endfunction

  function automatic logic [7:0] length_marker_char(logic [LEN_IDX_W-1:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h43;
      4'd1:    ch = 8'h6F;
      4'd2:    ch = 8'h6E;
      4'd3:    ch = 8'h74;
      4'd4:    ch = 8'h65;
      4'd5:    ch = 8'h6E;
      4'd6:    ch = 8'h74;
      4'd7:    ch = 8'h2D;
      4'd8:    ch = 8'h4C;
      4'd9:    ch = 8'h65;
      4'd10:   ch = 8'h6E;
      4'd11:   ch = 8'h67;
      4'd12:   ch = 8'h74;
      4'd13:   ch = 8'h68;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

### design/hrhp_in_if.sv
// Channel that carries header bytes into the parser.
interface hrhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;
  logic       is_last;

  modport source (output valid, header_byte, is_last, input ready);
  modport sink (input valid, header_byte, is_last, output ready);
endinterface

### design/hrhp_out_if.sv
// Channel that carries parse results out of the parser.
interface hrhp_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  status_code;
  logic [1:0]  status_result;
  logic [47:0] content_length;
  logic        length_overflow;

  modport source (output valid, status_code, status_result, content_length, length_overflow,
                  input ready);
  modport sink (input valid, status_code, status_result, content_length, length_overflow,
                output ready);
endinterface

### design/hrhp_status_match.sv
// Status line matcher: finds the version marker and reads the status code.
module hrhp_status_match
  import hrhp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  byte_ctl_t   ctl_i,
  output status_out_t res_o
);

  typedef enum logic [12:0] {
    ST_SEEK0 = 13'b0000000000001,
    ST_SEEK1 = 13'b0000000000010,
    ST_SEEK2 = 13'b0000000000100,
    ST_SEEK3 = 13'b0000000001000,
    ST_SEEK4 = 13'b0000000010000,
    ST_VER0  = 13'b0000000100000,
    ST_VER1  = 13'b0000001000000,
    ST_VER2  = 13'b0000010000000,
    ST_SKIP  = 13'b0000100000000,
    ST_DIG0  = 13'b0001000000000,
    ST_DIG1  = 13'b0010000000000,
    ST_DIG2  = 13'b0100000000000,
    ST_DONE  = 13'b1000000000000
  } status_state_e;

  status_state_e     state_q, state_d, state_n;
  logic [CODE_W-1:0] digits_q, digits_d, digits_n;
  status_res_e       outcome_q, outcome_d, outcome_n;
  logic [7:0]        c;
  logic              restart;

  assign c       = ctl_i.char;
  assign restart = (c == CH_H);

  always_comb begin
    state_n   = state_q;
    digits_n  = digits_q;
    outcome_n = outcome_q;
    if (ctl_i.active) begin
      unique case (state_q) inside
        ST_SEEK0: state_n = (c == CH_H) ? ST_SEEK1 : ST_SEEK0;
        ST_SEEK1: state_n = (c == CH_T) ? ST_SEEK2 : (restart ? ST_SEEK1 : ST_SEEK0);
        ST_SEEK2: state_n = (c == CH_T) ? ST_SEEK3 : (restart ? ST_SEEK1 : ST_SEEK0);
        ST_SEEK3: state_n = (c == CH_P) ? ST_SEEK4 : (restart ? ST_SEEK1 : ST_SEEK0);
        ST_SEEK4: begin
          if (c == CH_SLASH) begin
            state_n   = ST_VER0;
            outcome_n = RES_BAD_VERSION;
          end else begin
            state_n = restart ? ST_SEEK1 : ST_SEEK0;
          end
        end
        ST_VER0: state_n = (c == CH_ONE) ? ST_VER1 : ST_DONE;
        ST_VER1: state_n = (c == CH_DOT) ? ST_VER2 : ST_DONE;
        ST_VER2: begin
          if ((c == CH_ZERO) || (c == CH_ONE)) begin
            state_n   = ST_SKIP;
            outcome_n = RES_BAD_DIGITS;
          end else begin
            state_n = ST_DONE;
          end
        end
        ST_SKIP: state_n = ST_DIG0;
        ST_DIG0, ST_DIG1, ST_DIG2: begin
          if (is_digit(c)) begin
            digits_n = CODE_W'(digits_q * CODE_W'(10) + CODE_W'(digit_value(c)));
            if (state_q == ST_DIG0) begin
              state_n = ST_DIG1;
            end else if (state_q == ST_DIG1) begin
              state_n = ST_DIG2;
            end else begin
              state_n   = ST_DONE;
              outcome_n = RES_OK;
            end
          end else begin
            state_n = ST_DONE;
          end
        end
        default: state_n = ST_DONE;
      endcase
    end
  end

  assign res_o.result = outcome_n;
  assign res_o.code   = (outcome_n == RES_OK) ? digits_n : '0;

  always_comb begin
    if (ctl_i.finish) begin
      state_d   = ST_SEEK0;
      digits_d  = '0;
      outcome_d = RES_NO_MARKER;
    end else begin
      state_d   = state_n;
      digits_d  = digits_n;
      outcome_d = outcome_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_SEEK0;
      digits_q  <= '0;
      outcome_q <= RES_NO_MARKER;
    end else begin
      state_q   <= state_d;
      digits_q  <= digits_d;
      outcome_q <= outcome_d;
    end
  end

endmodule

### design/hrhp_length_match.sv
// Content-Length matcher: finds the field name and accumulates its decimal value.
module hrhp_length_match
  import hrhp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  byte_ctl_t   ctl_i,
  output length_out_t res_o
);

  typedef enum logic [4:0] {
    LN_SEARCH = 5'b00001,
    LN_SKIP   = 5'b00010,
    LN_NONDIG = 5'b00100,
    LN_DIGITS = 5'b01000,
    LN_VALID  = 5'b10000
  } length_state_e;

  length_state_e          state_q, state_d, state_n;
  logic [LEN_IDX_W-1:0]   idx_q, idx_d, idx_n;
  logic [LENGTH_BITS-1:0] acc_q, acc_d, acc_n;
  logic                   ovf_q, ovf_d, ovf_n;
  logic [7:0]             c;
  logic [3:0]             d;
  logic                   saturate;
  logic                   valid;

  assign c = ctl_i.char;
  assign d = digit_value(c);
  assign saturate = (acc_q > LEN_DIV10) || ((acc_q == LEN_DIV10) && (d > LEN_MOD10));

  always_comb begin
    state_n = state_q;
    idx_n   = idx_q;
    acc_n   = acc_q;
    ovf_n   = ovf_q;
    if (ctl_i.active) begin
      unique case (state_q)
        LN_SEARCH: begin
          if (c == length_marker_char(idx_q)) begin
            idx_n = idx_q + 1'b1;
            if (idx_n == LEN_IDX_W'(LEN_MARKER_LEN)) begin
              state_n = LN_SKIP;
            end
          end else begin
            idx_n = (c == CH_C) ? LEN_IDX_W'(1) : '0;
          end
        end
        LN_SKIP: state_n = LN_NONDIG;
        LN_NONDIG: begin
          if (is_digit(c)) begin
            acc_n   = LENGTH_BITS'(d);
            state_n = LN_DIGITS;
          end
        end
        LN_DIGITS: begin
          if (is_digit(c)) begin
            if (saturate) begin
              acc_n = LEN_MAX;
              ovf_n = 1'b1;
            end else begin
              acc_n = (acc_q << 3) + (acc_q << 1) + LENGTH_BITS'(d);
            end
          end else begin
            state_n = LN_VALID;
          end
        end
        LN_VALID: state_n = LN_VALID;
        default:  state_n = LN_SEARCH;
      endcase
    end
  end

  assign valid          = (state_n == LN_VALID);
  assign res_o.length   = valid ? OUT_LEN_W'(acc_n) : '0;
  assign res_o.overflow = valid && ovf_n;

  always_comb begin
    if (ctl_i.finish) begin
      state_d = LN_SEARCH;
      idx_d   = '0;
      acc_d   = '0;
      ovf_d   = 1'b0;
    end else begin
      state_d = state_n;
      idx_d   = idx_n;
      acc_d   = acc_n;
      ovf_d   = ovf_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LN_SEARCH;
      idx_q   <= '0;
      acc_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

### design/http_response_header_parser.sv
// Top level of the HTTP response header parser: input stage, matchers, result register.
//
//   Channel | Direction | Word                                        | Words per header
//   hdr_i   | in        | header_byte, is_last                        | one per byte
//   res_o   | out       | status_code, status_result, content_length, | one, on is_last
//           |           | length_overflow                             |
//
// One byte is taken every cycle while no last byte waits on a stalled result; a byte
// passes the input register and the matchers, and its result, if any, is captured in the result register.
// Reset clears the matchers, the end-of-string flag and both valid flags.
// A stalled result holds only bytes marked last; other bytes keep flowing.
module http_response_header_parser
  import hrhp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  hrhp_in_if.sink    hdr_i,
  hrhp_out_if.source res_o
);

  logic        s1_valid_q, s1_valid_d;
  logic [7:0]  s1_byte_q;
  logic        s1_last_q;
  logic        ended_q, ended_d;
  logic        out_valid_q, out_valid_d;
  status_out_t status_q, status_n;
  length_out_t length_q, length_n;
  logic        s2_free;
  logic        s1_take;
  logic        in_fire;
  byte_ctl_t   ctl;

  assign s2_free     = !out_valid_q || res_o.ready;
  assign s1_take     = s1_valid_q && (!s1_last_q || s2_free);
  assign hdr_i.ready = !s1_valid_q || s1_take;
  assign in_fire     = hdr_i.valid && hdr_i.ready;

  assign ctl.active = s1_take && !ended_q && (s1_byte_q != CH_NUL);
  assign ctl.finish = s1_take && s1_last_q;
  assign ctl.char   = s1_byte_q;

  assign s1_valid_d = in_fire ? 1'b1 : (s1_take ? 1'b0 : s1_valid_q);
  assign ended_d    = ctl.finish ? 1'b0
                    : ((s1_take && (s1_byte_q == CH_NUL)) ? 1'b1 : ended_q);
  assign out_valid_d = ctl.finish ? 1'b1 : (res_o.ready ? 1'b0 : out_valid_q);

  hrhp_status_match u_status (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .res_o  (status_n)
  );

  hrhp_length_match u_length (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .res_o  (length_n)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      ended_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      ended_q     <= ended_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= hdr_i.header_byte;
      s1_last_q <= hdr_i.is_last;
    end
    if (ctl.finish) begin
      status_q <= status_n;
      length_q <= length_n;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.status_code     = status_q.code;
  assign res_o.status_result   = status_q.result;
  assign res_o.content_length  = length_q.length;
  assign res_o.length_overflow = length_q.overflow;

endmodule

### design/http_response_header_parser_checker.sv
// Port-level checker for the HTTP response header parser and its bind statement.
`include "http_response_header_parser_macros.svh"

module http_response_header_parser_checker
  import hrhp_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic [CODE_W-1:0]    status_code_i,
  input logic [1:0]           status_result_i,
  input logic [OUT_LEN_W-1:0] content_length_i,
  input logic                 length_overflow_i
);

  logic [CODE_W+OUT_LEN_W+2:0] res_word;
  logic                        code_err;
  logic                        sat_hit;

  assign res_word = {status_code_i, status_result_i, content_length_i, length_overflow_i};
  assign code_err = out_valid_i && (status_result_i != RES_OK);
  assign sat_hit  = out_valid_i && length_overflow_i;

  `HRHP_ASSERT_HOLD(a_result_held, clk_i, rst_ni, out_valid_i, out_ready_i, res_word)
  `HRHP_ASSERT_IMPL(a_code_zero_on_error, clk_i, rst_ni, code_err, status_code_i == '0)
  `HRHP_ASSERT_IMPL(a_code_in_range, clk_i, rst_ni, out_valid_i, status_code_i <= CODE_W'(999))
  `HRHP_ASSERT_IMPL(a_overflow_saturates, clk_i, rst_ni, sat_hit, content_length_i == LEN_SAT_OUT)

endmodule

bind http_response_header_parser http_response_header_parser_checker u_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (res_o.valid),
  .out_ready_i       (res_o.ready),
  .status_code_i     (res_o.status_code),
  .status_result_i   (res_o.status_result),
  .content_length_i  (res_o.content_length),
  .length_overflow_i (res_o.length_overflow)
);
